### hdl/lif_pkg.sv
`timescale 1ns / 1ps
// lif_pkg: shared types, register indexes and microcode ROM for the LIF neuron.
// No dependencies.
package lif_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 15;
    localparam int PC_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_REST_VOLTAGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_VOLTAGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CURRENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REFR_LENGTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE    = 3'd6;

    localparam logic [PC_W-1:0] PC_SPIKE = 4'd9;
    localparam logic [PC_W-1:0] PC_REFR  = 4'd10;
    localparam logic [PC_W-1:0] PC_LAST  = 4'd10;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [1:0] { ST_IDLE = 2'b01, ST_RUN = 2'b10 } state_t;

    typedef enum logic [1:0] { MA_EXC, MA_ACC, MA_DECAY } mul_a_t;
    typedef enum logic [1:0] { MB_GATE, MB_RES, MB_DIFF } mul_b_t;
    typedef enum logic       { AX_FXP, AX_ACC } alu_x_t;
    typedef enum logic [2:0] { AY_BIAS, AY_OFFSET, AY_REST, AY_VOLT, AY_FXP } alu_y_t;
    typedef enum logic [1:0] { DST_NONE, DST_ACC, DST_DIFF, DST_VOLT } dst_t;
    typedef enum logic [1:0] { SP_NONE, SP_CLAMP, SP_SPIKE, SP_REFR } spec_t;
    typedef enum logic [1:0] { JC_NONE, JC_SPIKE, JC_REFR } jump_t;

    typedef struct packed {
        logic            mul_en;
        mul_a_t          ma;
        mul_b_t          mb;
        alu_x_t          ax;
        alu_y_t          ay;
        logic            alu_sub;
        dst_t            dst;
        spec_t           sp;
        jump_t           jc;
        logic [PC_W-1:0] target;
        logic            done;
    } uword_t;

    localparam uword_t UW_NOP = '{1'b0, MA_EXC, MB_GATE, AX_ACC, AY_BIAS, 1'b0,
                                  DST_NONE, SP_NONE, JC_NONE, '0, 1'b0};

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = UW_NOP;
        unique case (pc)
            4'd0:
            begin
                w.mul_en = 1'b1; w.ma = MA_EXC; w.mb = MB_GATE;
                w.jc = JC_SPIKE; w.target = PC_SPIKE;
            end
            4'd1:
            begin
                w.ax = AX_FXP; w.ay = AY_BIAS; w.dst = DST_ACC;
                w.jc = JC_REFR; w.target = PC_REFR;
            end
            4'd2:
            begin
                w.ax = AX_ACC; w.ay = AY_OFFSET; w.dst = DST_ACC;
            end
            4'd3:
            begin
                w.mul_en = 1'b1; w.ma = MA_ACC; w.mb = MB_RES;
            end
            4'd4:
            begin
                w.ax = AX_FXP; w.ay = AY_REST; w.dst = DST_ACC;
            end
            4'd5:
            begin
                w.ax = AX_ACC; w.ay = AY_VOLT; w.alu_sub = 1'b1; w.dst = DST_DIFF;
            end
            4'd6:
            begin
                w.mul_en = 1'b1; w.ma = MA_DECAY; w.mb = MB_DIFF;
            end
            4'd7:
            begin
                w.ax = AX_ACC; w.ay = AY_FXP; w.alu_sub = 1'b1; w.dst = DST_VOLT;
            end
            4'd8:
            begin
                w.sp = SP_CLAMP; w.done = 1'b1;
            end
            4'd9:
            begin
                w.sp = SP_SPIKE; w.done = 1'b1;
            end
            4'd10:
            begin
                w.sp = SP_REFR; w.done = 1'b1;
            end
            default:
            begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > S32_MAX)
            r = S32_MAX[DATA_W-1:0];
        else if (x < S32_MIN)
            r = S32_MIN[DATA_W-1:0];
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage

### hdl/lif_neuron_gated_update.sv
`timescale 1ns / 1ps
// lif_neuron_gated_update: leaky integrate-and-fire neuron, s16.15 fixed point.
// Depends on lif_pkg (types, microcode ROM, saturation).
//
// Usage:
//   Input channel (in_valid/in_ready): operation 0 is a timestep transfer carrying
//   excitatory_in, gating_in and bias_in; operation 1 is a spike transfer that loads
//   reset_voltage and refractory_length. Every transfer yields one voltage_out
//   transfer on the output channel (out_valid/out_ready).
//   A microcode sequencer steps one shared 32x32 multiplier and one saturating adder.
//   An active timestep runs through the clamp step, passing three dependent multiplies
//   through the single multiplier; while refractory it jumps to the countdown step, and
//   a spike jumps to the reset step. in_ready returns in the same cycle that out_valid
//   rises with the loaded result, so no new item is taken before the program ends.
//   The output register holds one result; a new item is accepted while it waits.
//   If the receiver stalls and a second result is ready, the sequencer holds on its
//   final step until the output register frees.
//   Configuration: cfg_wr_en writes cfg_data to register cfg_index at once; write
//   only while idle. Index 7 is ignored.
//   Reset (rst_n low, asynchronous): voltage and refractory count clear, configuration
//   registers return to defaults, both channels go idle.
module lif_neuron_gated_update
    import lif_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [DATA_W-1:0] excitatory_in,
    input  logic signed [DATA_W-1:0] gating_in,
    input  logic signed [DATA_W-1:0] bias_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] voltage_out
);

    state_t                   state_reg, state_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] volt_reg, volt_next;
    logic [15:0]              refr_reg, refr_next;

    logic signed [DATA_W-1:0] rest_reg, reset_v_reg, offset_reg, max_reg;
    logic [30:0]              res_reg;
    logic [15:0]              decay_reg, refr_len_reg;

    logic                     op_reg;
    logic signed [DATA_W-1:0] exc_reg, gate_reg, bias_reg;
    logic signed [DATA_W-1:0] acc_reg, diff_reg, vout_reg;
    logic signed [63:0]       prod_reg;

    uword_t                   uw;
    logic                     running, advance, taken, in_xfer;
    logic signed [DATA_W-1:0] mul_a, mul_b, fxp, alu_x, alu_y, alu_res;
    logic signed [63:0]       mul_p, alu_sum;

    assign uw      = ucode(pc_reg);
    assign running = (state_reg == ST_RUN);
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer = in_valid && in_ready;
    assign advance = running && !(uw.done && out_valid_reg && !out_ready);
    assign out_valid = out_valid_reg;
    assign voltage_out = vout_reg;

    always_comb
    begin
        unique case (uw.ma)
            MA_EXC:   mul_a = exc_reg;
            MA_ACC:   mul_a = acc_reg;
            MA_DECAY: mul_a = $signed({16'd0, decay_reg});
            default:  mul_a = exc_reg;
        endcase
        unique case (uw.mb)
            MB_GATE: mul_b = gate_reg;
            MB_RES:  mul_b = $signed({1'b0, res_reg});
            MB_DIFF: mul_b = diff_reg;
            default: mul_b = gate_reg;
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign fxp   = sat32(prod_reg >>> FRAC_W);

    always_comb
    begin
        unique case (uw.ax)
            AX_FXP:  alu_x = fxp;
            AX_ACC:  alu_x = acc_reg;
            default: alu_x = acc_reg;
        endcase
        unique case (uw.ay)
            AY_BIAS:   alu_y = bias_reg;
            AY_OFFSET: alu_y = offset_reg;
            AY_REST:   alu_y = rest_reg;
            AY_VOLT:   alu_y = volt_reg;
            AY_FXP:    alu_y = fxp;
            default:   alu_y = bias_reg;
        endcase
    end

    assign alu_sum = uw.alu_sub ? (64'(alu_x) - 64'(alu_y)) : (64'(alu_x) + 64'(alu_y));
    assign alu_res = sat32(alu_sum);

    always_comb
    begin
        taken = 1'b0;
        unique case (uw.jc)
            JC_NONE:  taken = 1'b0;
            JC_SPIKE: taken = op_reg;
            JC_REFR:  taken = (refr_reg != 16'd0);
            default:  taken = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        volt_next      = volt_reg;
        refr_next      = refr_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    pc_next = taken ? uw.target : pc_reg + 1'b1;
                    if (uw.dst == DST_VOLT)
                        volt_next = alu_res;
                    unique case (uw.sp)
                        SP_NONE:  ;
                        SP_CLAMP: volt_next = (volt_reg > max_reg) ? max_reg : volt_reg;
                        SP_SPIKE:
                        begin
                            volt_next = reset_v_reg;
                            refr_next = refr_len_reg;
                        end
                        SP_REFR:  refr_next = refr_reg - 16'd1;
                        default:  ;
                    endcase
                    if (uw.done)
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            volt_reg      <= '0;
            refr_reg      <= '0;
            rest_reg      <= '0;
            reset_v_reg   <= '0;
            offset_reg    <= '0;
            res_reg       <= 31'd32768;
            decay_reg     <= 16'd32768;
            refr_len_reg  <= '0;
            max_reg       <= S32_MAX[DATA_W-1:0];
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            volt_reg      <= volt_next;
            refr_reg      <= refr_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_REST_VOLTAGE:   rest_reg     <= cfg_data;
                    REG_RESET_VOLTAGE:  reset_v_reg  <= cfg_data;
                    REG_OFFSET_CURRENT: offset_reg   <= cfg_data;
                    REG_RESISTANCE:     res_reg      <= cfg_data[30:0];
                    REG_DECAY_FACTOR:   decay_reg    <= cfg_data[15:0];
                    REG_REFR_LENGTH:    refr_len_reg <= cfg_data[15:0];
                    REG_MAX_VOLTAGE:    max_reg      <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= operation;
            exc_reg  <= excitatory_in;
            gate_reg <= gating_in;
            bias_reg <= bias_in;
        end
        if (advance)
        begin
            if (uw.mul_en)
                prod_reg <= mul_p;
            if (uw.dst == DST_ACC)
                acc_reg <= alu_res;
            if (uw.dst == DST_DIFF)
                diff_reg <= alu_res;
            if (uw.done)
                vout_reg <= volt_next;
        end
    end

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        running |-> (pc_reg <= PC_LAST))
        else $error("microcode step out of program");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (running && pc_reg == '0))
        else $error("transfer did not start the program at step zero");

    a_clamp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && uw.sp == SP_CLAMP) |=> (volt_reg <= $past(max_reg)))
        else $error("voltage above clamp after update");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(vout_reg)))
        else $error("pending result overwritten");
`endif

endmodule
